// ===== hdl/fcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcw_pkg
// Shared widths, codes and types of the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
package fcw_pkg;

  // field widths
  localparam int CLU_W     = 12;
  localparam int CNT_W     = 6;
  localparam int ST_W      = 2;
  localparam int IDX_W     = 13;
  localparam int LEN_W     = 14;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 14;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_CHAIN   = 2'd1;
  localparam logic [ST_W-1:0] ST_CLUSTER = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FAT_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_LIMIT = 2'd1;

  // input item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_WALK = 1'b1;

  // special FAT12 entry values
  localparam logic [CLU_W-1:0] CLU_FREE    = 12'h000;
  localparam logic [CLU_W-1:0] CLU_FIRST   = 12'h002;
  localparam logic [CLU_W-1:0] CLU_BAD     = 12'hFF7;
  localparam logic [CLU_W-1:0] CLU_EOC_MIN = 12'hFF8;

  // register reset values
  localparam logic [LEN_W-1:0] FAT_LENGTH_RST  = 14'd4608;
  localparam logic [CNT_W-1:0] CHAIN_LIMIT_RST = 6'd63;

  typedef struct packed {
    logic [CLU_W-1:0] cluster;
    logic [CNT_W-1:0] count;
    logic [ST_W-1:0]  status;
    logic             last;
  } fcw_result_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } fcw_mem_req_t;

endpackage

// ===== hdl/fcw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcw_if
// Valid/ready channels of the walker: input items, results, configuration.
// ----------------------------------------------------------------------------
interface fcw_item_if import fcw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [IDX_W-1:0] byte_index;
  logic [7:0]       byte_value;
  logic [CLU_W-1:0] first_cluster;

  modport source (output valid, kind, byte_index, byte_value, first_cluster,
                  input ready);
  modport sink (input valid, kind, byte_index, byte_value, first_cluster,
                output ready);
endinterface

interface fcw_result_if import fcw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CLU_W-1:0] cluster;
  logic [CNT_W-1:0] count;
  logic [ST_W-1:0]  status;
  logic             last;

  modport source (output valid, cluster, count, status, last, input ready);
  modport sink (input valid, cluster, count, status, last, output ready);
endinterface

interface fcw_cfg_if import fcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/fcw_fat_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcw_fat_mem
// FAT byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fcw_fat_mem import fcw_pkg::*; #(
  parameter int STORE_BYTES = 8192
) (
  input  logic         clk,
  input  fcw_mem_req_t req,
  output logic [7:0]   rd_data
);

  localparam int AW = $clog2(STORE_BYTES);

  logic [7:0] mem [STORE_BYTES];

  // write and registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr[AW-1:0]];
    end
  end

endmodule

// ===== hdl/fcw_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcw_out_stage
// Result register that decouples the walker from the result consumer.
// ----------------------------------------------------------------------------
module fcw_out_stage import fcw_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  fcw_result_t  push_res,
  output logic         free,
  fcw_result_if.source result
);

  logic        valid;
  logic        valid_next;
  fcw_result_t res;

  // slot is free when empty or being drained this cycle
  assign free = !valid || result.ready;

  always_comb begin
    valid_next = valid;
    if (push) begin
      valid_next = 1'b1;
    end else if (result.ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // payload holds until the next push
  always_ff @(posedge clk) begin
    if (push) begin
      res <= push_res;
    end
  end

  assign result.valid   = valid;
  assign result.cluster = res.cluster;
  assign result.count   = res.count;
  assign result.status  = res.status;
  assign result.last    = res.last;

endmodule

// ===== hdl/fcw_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcw_walker
// Chain walk sequencer: loads FAT bytes, reads entries and emits clusters.
// ----------------------------------------------------------------------------
module fcw_walker import fcw_pkg::*; #(
  parameter int STORE_BYTES = 8192,
  parameter int MAX_CHAIN = 63
) (
  input  logic         clk,
  input  logic         rst,
  fcw_item_if.sink     item,
  fcw_cfg_if.sink      cfg,
  input  logic [7:0]   rd_data,
  output fcw_mem_req_t mem_req,
  input  logic         out_free,
  output logic         out_push,
  output fcw_result_t  out_res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RD_HI,
    S_DECODE,
    S_EMIT
  } state_t;

  state_t           state;
  logic [CLU_W-1:0] cur;
  logic [CNT_W-1:0] n;
  logic [IDX_W-1:0] off;
  logic [7:0]       lo;
  fcw_result_t      pending;
  logic             pend_err2;
  logic [LEN_W-1:0] fat_length;
  logic [CNT_W-1:0] chain_limit;

  logic             item_acc;
  logic [CNT_W-1:0] limit;
  logic [LEN_W-1:0] usable_len;
  logic [LEN_W-1:0] tri_off;
  logic [IDX_W-1:0] cur_off;
  logic [LEN_W-1:0] off_end;
  logic             chain_bad;
  logic             range_bad;
  logic [15:0]      entry_word;
  logic [CLU_W-1:0] next_clu;
  fcw_result_t      dec_res;

  assign item.ready = (state == S_IDLE);
  assign item_acc   = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  // effective limits
  assign limit      = (chain_limit < CNT_W'(MAX_CHAIN)) ? chain_limit : CNT_W'(MAX_CHAIN);
  assign usable_len = (fat_length < LEN_W'(STORE_BYTES)) ? fat_length : LEN_W'(STORE_BYTES);

  // byte offset cur*3/2 and bounds checks
  assign tri_off   = {1'b0, cur, 1'b0} + {2'b00, cur};
  assign cur_off   = tri_off[LEN_W-1:1];
  assign off_end   = {1'b0, cur_off} + LEN_W'(1);
  assign chain_bad = (cur == CLU_FREE) || (cur == CLU_BAD) || (n >= limit);
  assign range_bad = (cur < CLU_FIRST) || (off_end >= usable_len);

  // entry decode from the little-endian byte pair
  assign entry_word = {rd_data, lo};
  assign next_clu   = cur[0] ? entry_word[15:4] : entry_word[CLU_W-1:0];
  assign dec_res    = '{cluster: cur, count: n, status: ST_OK,
                        last: (next_clu >= CLU_EOC_MIN)};

  // memory port: loads only in idle, reads only during a walk
  always_comb begin
    mem_req.we    = item_acc && (item.kind == KIND_LOAD) &&
                    ({1'b0, item.byte_index} < LEN_W'(STORE_BYTES));
    mem_req.waddr = item.byte_index;
    mem_req.wdata = item.byte_value;
    mem_req.re    = 1'b0;
    mem_req.raddr = cur_off;
    case (state)
      S_CHECK: begin
        mem_req.re = !chain_bad && !range_bad;
      end
      S_RD_HI: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = off + IDX_W'(1);
      end
      default: begin
        mem_req.re = 1'b0;
      end
    endcase
  end

  // result push toward the output register
  always_comb begin
    out_push = 1'b0;
    out_res  = pending;
    case (state)
      S_DECODE: begin
        out_push = out_free;
        out_res  = dec_res;
      end
      S_EMIT: begin
        out_push = out_free;
      end
      default: begin
        out_push = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fat_length  <= FAT_LENGTH_RST;
      chain_limit <= CHAIN_LIMIT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_FAT_LENGTH:  fat_length  <= cfg.data[LEN_W-1:0];
        CFG_CHAIN_LIMIT: chain_limit <= cfg.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // walk sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend_err2 <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_acc && (item.kind == KIND_WALK)) begin
            cur       <= item.first_cluster;
            n         <= '0;
            pend_err2 <= 1'b0;
            if (item.first_cluster < CLU_FIRST) begin
              pending <= '{cluster: '0, count: '0, status: ST_CLUSTER, last: 1'b1};
              state   <= S_EMIT;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (chain_bad) begin
            pending   <= '{cluster: '0, count: n, status: ST_CHAIN, last: 1'b1};
            pend_err2 <= 1'b0;
            state     <= S_EMIT;
          end else begin
            n <= n + CNT_W'(1);
            if (range_bad) begin
              // visited cluster first, cluster error after it
              pending   <= '{cluster: cur, count: n + CNT_W'(1), status: ST_OK,
                             last: 1'b0};
              pend_err2 <= 1'b1;
              state     <= S_EMIT;
            end else begin
              off   <= cur_off;
              state <= S_RD_HI;
            end
          end
        end
        S_RD_HI: begin
          lo    <= rd_data;
          state <= S_DECODE;
        end
        S_DECODE: begin
          cur <= next_clu;
          if (out_free) begin
            state <= dec_res.last ? S_IDLE : S_CHECK;
          end else begin
            pending   <= dec_res;
            pend_err2 <= 1'b0;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (pend_err2) begin
              pending   <= '{cluster: '0, count: n, status: ST_CLUSTER, last: 1'b1};
              pend_err2 <= 1'b0;
            end else begin
              state <= pending.last ? S_IDLE : S_CHECK;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/fat12_cluster_chain_walker_top.sv =====
`timescale 1ns / 1ps
// Load item: accepted while idle, written to the FAT store at the accepting edge.
// Walk item: per chain cluster a check, then two byte reads over the
// single FAT store read port; an entry past the table gives the cluster's
// result and then a cluster error result. Output stalls hold the walk.
// Reset: synchronous, clears control and configuration; FAT store undefined.
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_top
// FAT12 cluster chain walker: byte store load and chain walk with status.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker_top import fcw_pkg::*; #(
  parameter int STORE_BYTES = 8192,
  parameter int MAX_CHAIN = 63
) (
  input  logic         clk,
  input  logic         rst,
  fcw_item_if.sink     item,
  fcw_cfg_if.sink      cfg,
  fcw_result_if.source result
);

  fcw_mem_req_t mem_req;
  logic [7:0]   rd_data;
  logic         out_free;
  logic         out_push;
  fcw_result_t  out_res;

  // walk sequencer
  fcw_walker #(
    .STORE_BYTES (STORE_BYTES),
    .MAX_CHAIN   (MAX_CHAIN)
  ) u_walker (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg      (cfg),
    .rd_data  (rd_data),
    .mem_req  (mem_req),
    .out_free (out_free),
    .out_push (out_push),
    .out_res  (out_res)
  );

  // FAT byte store
  fcw_fat_mem #(
    .STORE_BYTES (STORE_BYTES)
  ) u_fat_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // result register
  fcw_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .push     (out_push),
    .push_res (out_res),
    .free     (out_free),
    .result   (result)
  );

endmodule

// ===== hdl/fcw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcw_checker
// Port level checks of the chain walker, bound to the top level.
// ----------------------------------------------------------------------------
module fcw_checker import fcw_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input logic             item_kind,
  input logic             res_valid,
  input logic             res_ready,
  input logic [CLU_W-1:0] res_cluster,
  input logic [CNT_W-1:0] res_count,
  input logic [ST_W-1:0]  res_status,
  input logic             res_last
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // stalled result holds its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_cluster) &&
      $stable(res_count) && $stable(res_status) && $stable(res_last))
    else $error("stalled result changed");

  // an error result ends the walk and carries no cluster
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status != ST_OK) |-> res_last && (res_cluster == '0))
    else $error("error result not last or with a cluster");

  // a walk holds off further items
  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item_kind == KIND_WALK) |=> !item_ready)
    else $error("item accepted during a walk");

endmodule

bind fat12_cluster_chain_walker_top fcw_checker u_fcw_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item.valid),
  .item_ready  (item.ready),
  .item_kind   (item.kind),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_cluster (result.cluster),
  .res_count   (result.count),
  .res_status  (result.status),
  .res_last    (result.last)
);

// ===== tb/sv/fat12_cluster_chain_walker_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_top_tb
// Self-checking bench for the FAT12 chain walker. It loads FAT entries byte
// by byte, walks well-formed and broken chains, and predicts every emitted
// cluster, count, status and last flag. Results are checked in order as they
// leave the block, under random idling on both channels and one long output
// stall.
// ----------------------------------------------------------------------------
import fcw_pkg::*;

localparam int FAT_SIZE  = 8192;
localparam int CHAIN_MAX = 63;

// in-order prediction of the walker and its FAT byte store
class fat_chain_scoreboard;
  logic [7:0]  fat [FAT_SIZE];
  bit          loaded [FAT_SIZE];
  int unsigned fat_len;
  int unsigned chain_lim;
  fcw_result_t pending[$];
  int          errors;

  function new();
    fat_len   = int'(FAT_LENGTH_RST);
    chain_lim = int'(CHAIN_LIMIT_RST);
    errors    = 0;
  endfunction

  function void set_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned d);
    if (idx == CFG_FAT_LENGTH) begin
      fat_len = d & 32'h3FFF;
    end else if (idx == CFG_CHAIN_LIMIT) begin
      chain_lim = d & 32'h3F;
    end
  endfunction

  function fcw_result_t result_of(logic [CLU_W-1:0] c, int unsigned n,
                                  logic [ST_W-1:0] st, logic fin);
    fcw_result_t r;
    r.cluster = c;
    r.count   = CNT_W'(n);
    r.status  = st;
    r.last    = fin;
    return r;
  endfunction

  // follows the chain from start; returns the first unloaded byte it would
  // read, or -1 when the whole walk is defined
  function int trace_chain(logic [CLU_W-1:0] start, ref fcw_result_t outs[$]);
    int unsigned lim, len, n, off;
    logic [CLU_W-1:0] cur, nxt;
    logic [15:0] pair;
    outs.delete();
    lim = (chain_lim < CHAIN_MAX) ? chain_lim : CHAIN_MAX;
    len = (fat_len < FAT_SIZE) ? fat_len : FAT_SIZE;
    cur = start;
    n   = 0;
    if (cur < CLU_FIRST) begin
      outs.push_back(result_of(CLU_FREE, 0, ST_CLUSTER, 1'b1));
      return -1;
    end
    while (1'b1) begin
      // free or bad link, or chain too long
      if (cur == CLU_FREE || cur == CLU_BAD || n >= lim) begin
        outs.push_back(result_of(CLU_FREE, n, ST_CHAIN, 1'b1));
        return -1;
      end
      n++;
      off = (int'(cur) * 3) / 2;
      // link below two or entry past the table end
      if (cur < CLU_FIRST || off + 1 >= len) begin
        outs.push_back(result_of(cur, n, ST_OK, 1'b0));
        outs.push_back(result_of(CLU_FREE, n, ST_CLUSTER, 1'b1));
        return -1;
      end
      if (!loaded[off]) return int'(off);
      if (!loaded[off+1]) return int'(off + 1);
      pair = {fat[off+1], fat[off]};
      nxt  = cur[0] ? pair[15:4] : pair[11:0];
      if (nxt >= CLU_EOC_MIN) begin
        outs.push_back(result_of(cur, n, ST_OK, 1'b1));
        return -1;
      end
      outs.push_back(result_of(cur, n, ST_OK, 1'b0));
      cur = nxt;
    end
    return -1;
  endfunction

  function void note_item(logic k, logic [IDX_W-1:0] idx, logic [7:0] val,
                          logic [CLU_W-1:0] sc);
    fcw_result_t outs[$];
    if (k == KIND_LOAD) begin
      fat[idx]    = val;
      loaded[idx] = 1'b1;
    end else begin
      void'(trace_chain(sc, outs));
      foreach (outs[i]) pending.push_back(outs[i]);
    end
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned seen);
    if (want != seen) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
      errors++;
    end
  endfunction

  function void check_result(fcw_result_t got);
    fcw_result_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result: expected none, %s%0d count=%0d status=%0d last=%0d",
               $time, "actual cluster=", got.cluster, got.count, got.status,
               got.last);
      errors++;
      return;
    end
    want = pending.pop_front();
    compare_field("cluster", want.cluster, got.cluster);
    compare_field("count", want.count, got.count);
    compare_field("status", want.status, got.status);
    compare_field("last", want.last, got.last);
  endfunction
endclass

module fat12_cluster_chain_walker_top_tb;

  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fcw_item_if   item_ch();
  fcw_cfg_if    cfg_ch();
  fcw_result_if res_ch();

  fat_chain_scoreboard sb = new();

  int items_sent = 0;
  bit calm       = 1'b0;
  bit want_hold  = 1'b0;
  bit hold_done  = 1'b0;

  fat12_cluster_chain_walker_top #(
    .STORE_BYTES(FAT_SIZE),
    .MAX_CHAIN(CHAIN_MAX)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .cfg(cfg_ch),
    .result(res_ch)
  );

  always #4 clk = ~clk;

  // result ready: random stalls, one long hold-off, steady at the end
  initial begin : result_ready_gen
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (want_hold && !hold_done) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result(fcw_result_t'({res_ch.cluster, res_ch.count, res_ch.status,
                                     res_ch.last}));
  end

  // one input transaction, with an optional idle burst ahead of it
  task automatic send_item(input logic k, input logic [IDX_W-1:0] idx,
                           input logic [7:0] val, input logic [CLU_W-1:0] sc);
    if (!calm && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.kind          <= k;
    item_ch.byte_index    <= idx;
    item_ch.byte_value    <= val;
    item_ch.first_cluster <= sc;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note_item(k, idx, val, sc);
    items_sent++;
  endtask

  task automatic load_byte(input logic [IDX_W-1:0] idx, input logic [7:0] val);
    send_item(KIND_LOAD, idx, val, CLU_W'($urandom));
  endtask

  // read-modify-write of the two bytes that hold one 12-bit entry
  task automatic write_entry(input logic [CLU_W-1:0] c, input logic [CLU_W-1:0] v);
    int unsigned off;
    logic [7:0] b0, b1;
    off = (int'(c) * 3) / 2;
    b0  = sb.loaded[off] ? sb.fat[off] : 8'($urandom);
    b1  = sb.loaded[off+1] ? sb.fat[off+1] : 8'($urandom);
    if (c[0]) begin
      b0[7:4] = v[3:0];
      b1      = v[11:4];
    end else begin
      b0      = v[7:0];
      b1[3:0] = v[11:8];
    end
    load_byte(IDX_W'(off), b0);
    load_byte(IDX_W'(off + 1), b1);
  endtask

  // fill any unloaded byte the walk would touch, mostly with end marks
  task automatic walk_from(input logic [CLU_W-1:0] s);
    fcw_result_t scratch[$];
    int hole;
    hole = sb.trace_chain(s, scratch);
    while (hole >= 0) begin
      load_byte(IDX_W'(hole), ($urandom_range(0, 3) != 0) ? 8'hFF : 8'($urandom));
      hole = sb.trace_chain(s, scratch);
    end
    send_item(KIND_WALK, IDX_W'($urandom), 8'($urandom), s);
  endtask

  // wait for every expected result, then let the block go quiet
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // both registers in one burst, with the block idle
  task automatic configure(input int unsigned len, input int unsigned lim);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_FAT_LENGTH;
    cfg_ch.data  <= CFG_DAT_W'(len);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_cfg(CFG_FAT_LENGTH, len);
    cfg_ch.index <= CFG_CHAIN_LIMIT;
    cfg_ch.data  <= CFG_DAT_W'(lim);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_cfg(CFG_CHAIN_LIMIT, lim);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly well-formed chains with random links and endings, plus noise
  task automatic random_phase(input int goal);
    int unsigned len_eff, maxc, n, i;
    bit dup;
    logic [CLU_W-1:0] chain[$];
    logic [CLU_W-1:0] c, tail;
    while (items_sent < goal) begin
      len_eff = (sb.fat_len < FAT_SIZE) ? sb.fat_len : FAT_SIZE;
      maxc    = (len_eff >= 5) ? (2 * (len_eff - 2)) / 3 : 0;
      if (maxc > 4095) maxc = 4095;
      if (maxc >= 2 && $urandom_range(0, 9) < 7) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        if (n > maxc - 1) n = maxc - 1;
        chain.delete();
        while (chain.size() < n) begin
          c   = CLU_W'($urandom_range(2, maxc));
          dup = 1'b0;
          foreach (chain[j]) if (chain[j] == c) dup = 1'b1;
          if (!dup) chain.push_back(c);
        end
        for (i = 0; i + 1 < chain.size(); i++) write_entry(chain[i], chain[i+1]);
        case ($urandom_range(0, 9))
          0: tail = CLU_FREE;
          1: tail = CLU_BAD;
          2: tail = CLU_W'($urandom_range(0, 1));
          3: tail = (maxc < 4095) ? CLU_W'($urandom_range(maxc + 1, 4095))
                                  : CLU_W'($urandom_range(2, 4094));
          4: tail = chain[$urandom_range(0, chain.size() - 1)];
          default: tail = CLU_W'($urandom_range(int'(CLU_EOC_MIN), 4095));
        endcase
        write_entry(chain[chain.size()-1], tail);
        walk_from(chain[0]);
      end else if ($urandom_range(0, 1) == 0) begin
        load_byte(IDX_W'($urandom), 8'($urandom));
      end else begin
        walk_from(CLU_W'($urandom));
      end
    end
  endtask

  // stimulus
  initial begin : stimulus
    item_ch.valid         <= 1'b0;
    item_ch.kind          <= KIND_LOAD;
    item_ch.byte_index    <= '0;
    item_ch.byte_value    <= '0;
    item_ch.first_cluster <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= CFG_FAT_LENGTH;
    cfg_ch.data           <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes and every ending of a walk, reset settings
    load_byte(IDX_W'(FAT_SIZE - 1), 8'hFF);
    walk_from(12'd0);
    walk_from(12'd1);
    walk_from(12'd4095);
    walk_from(CLU_BAD);
    write_entry(12'd2, 12'd3);
    write_entry(12'd3, 12'hFFF);
    walk_from(12'd2);
    write_entry(12'd5, CLU_FREE);
    walk_from(12'd5);
    write_entry(12'd6, CLU_BAD);
    walk_from(12'd6);
    write_entry(12'd7, 12'd1);
    walk_from(12'd7);
    write_entry(12'd8, 12'd4000);
    walk_from(12'd8);
    write_entry(12'd9, CLU_EOC_MIN);
    walk_from(12'd9);
    write_entry(12'd10, 12'd10);
    walk_from(12'd10);

    // random, with one long output stall early on
    want_hold = 1'b1;
    random_phase(110);
    configure(0, 1);
    random_phase(150);
    configure(8192, 63);
    random_phase(230);
    configure($urandom_range(40, 600), $urandom_range(2, 8));
    random_phase(300);
    configure(int'(FAT_LENGTH_RST), 63);
    calm = 1'b1;
    random_phase(380);

    settle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
